FILE: rtl/midi_track_event_parser_assert.svh
// assertion macros used by the rtl queue module mtep_fifo
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// property that must hold at every edge out of reset
`define MTEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define MTEP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// shared types and constants of the midi track event parser
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned OutTicksPerQuarter = 768;
  localparam int unsigned OtpqW  = 16;
  localparam int unsigned TpqW   = 15;
  localparam int unsigned NumW   = 32 + OtpqW;
  localparam int unsigned Chans  = 16;
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] KIND_CHAN  = 3'd0;
  localparam logic [2:0] KIND_PROG  = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_TSIG  = 3'd3;
  localparam logic [2:0] KIND_SYSEX = 3'd4;

  localparam logic CFG_TPQ  = 1'b0;
  localparam logic CFG_PCAP = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] event_time;
    logic [7:0]  status;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [3:0]  instrument_flags;
    logic [7:0]  bank_high;
    logic [7:0]  bank_low;
    logic [31:0] tempo_micros;
    logic [31:0] sysex_length;
  } rec_t;

endpackage

FILE: rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// standard midi file track parser with tick rescaling
// ----------------------------------------------------------------------------
// bytes of a track enter on the s_axis channel, one per transfer, with
// tuser flagging track and file starts. decoded events leave on m_axis.
// cfg_we_i writes ticks_per_quarter (index 0) or program_capture (index 1);
// the user writes them only while the block is idle; the block does not enforce this.
// the parser takes one byte per cycle while the two-entry result queue has
// room. channel and sysex events go from the queue straight into the output
// register. program, tempo and time signature events pass through a
// bit-serial divider, one quotient bit per cycle of a 48-bit numerator,
// and wait in ST_HOLD for the output register; the next queued event is
// popped only once the last one has left the divider.
// when m_axis_tready is low the output register holds, the queue fills and
// then s_axis_tready drops. reset clears parser state, banks to 255 and the
// configuration to 768 ticks and program capture off.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte
  input  logic [1:0]    s_axis_tuser,   // track_begin, file_begin
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // kind, event_time, status, first_data, second_data, instrument_flags,
  // bank_high, bank_low, tempo_micros, sysex_length, zero pad
  output logic [143:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [14:0]   cfg_data_i
);
  import mtep_pkg::*;

  logic [TpqW-1:0] tpq_q;
  logic            pcap_q;
  logic            acc;
  logic            push, pop, full, empty;
  rec_t            wrec, rrec, orec;

  assign s_axis_tready = !full;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q  <= TpqW'(768);
      pcap_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TPQ:  tpq_q  <= cfg_data_i;
        CFG_PCAP: pcap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mtep_front u_front (
    .clk_i,
    .rst_ni,
    .acc_i         (acc),
    .byte_i        (s_axis_tdata),
    .track_begin_i (s_axis_tuser[0]),
    .file_begin_i  (s_axis_tuser[1]),
    .prog_cap_i    (pcap_q),
    .push_o        (push),
    .rec_o         (wrec)
  );

  mtep_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (wrec),
    .pop_i   (pop),
    .rdata_o (rrec),
    .full_o  (full),
    .empty_o (empty)
  );

  mtep_back u_back (
    .clk_i,
    .rst_ni,
    .tpq_i       (tpq_q),
    .empty_i     (empty),
    .rdata_i     (rrec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (orec)
  );

  assign m_axis_tdata = {1'b0, orec.sysex_length, orec.tempo_micros, orec.bank_low,
                         orec.bank_high, orec.instrument_flags, orec.second_data,
                         orec.first_data, orec.status, orec.event_time, orec.kind};

endmodule

FILE: rtl/mtep_front.sv
// ----------------------------------------------------------------------------
// mtep_front
// byte parser: delta times, running status, meta and sysex decode
// ----------------------------------------------------------------------------
module mtep_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    byte_i,
  input  logic          track_begin_i,
  input  logic          file_begin_i,
  input  logic          prog_cap_i,
  output logic          push_o,
  output mtep_pkg::rec_t rec_o
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA, PH_EVENT, PH_DATA1, PH_DATA2, PH_SYSLEN, PH_SYSDATA, PH_F7LEN,
    PH_SKIP, PH_METATYPE, PH_METALEN, PH_TEMPO, PH_TSBEATS, PH_TSEXP
  } phase_e;

  function automatic logic gs_sound(logic [6:0] msb, logic [6:0] lsb, logic [6:0] p);
    logic r;
    r = 1'b0;
    if (lsb == 7'd0) begin
      case (msb)
        7'd0: r = 1'b1;
        7'd6, 7'd7: r = (p == 7'h7D);
        7'd24: r = (p == 7'h04) || (p == 7'h06);
        7'd9: r = (p == 7'h0E) || (p == 7'h76) || (p == 7'h7D);
        7'd2: r = (p == 7'h66) || (p == 7'h78) || (p > 7'h79);
        7'd3: r = (p > 7'h79);
        7'd4, 7'd5: r = (p == 7'h7A) || ((p > 7'h7B) && (p < 7'h7F));
        7'd32: r = (p == 7'h10) || (p == 7'h11) || (p == 7'h18) || (p == 7'h34);
        7'd1: r = (p == 7'h26) || (p == 7'h39) || (p == 7'h3C) || (p == 7'h50) ||
                  (p == 7'h51) || (p == 7'h62) || (p == 7'h66) || (p == 7'h68) ||
                  (p > 7'h77);
        7'd16: r = (p == 7'h00) || (p == 7'h04) || (p == 7'h05) || (p == 7'h06) ||
                   (p == 7'h10) || (p == 7'h13) || (p == 7'h18) || (p == 7'h19) ||
                   (p == 7'h1C) || (p == 7'h27) || (p == 7'h3E) || (p == 7'h3F);
        7'd8: begin
          if ((p < 7'h07) || (p == 7'h7D)) r = 1'b1;
          else if ((p > 7'h3F) && (p < 7'h50)) r = 1'b0;
          else if ((p > 7'h4F) && (p < 7'h72))
            r = (p == 7'h50) || (p == 7'h51) || (p == 7'h6B);
          else if ((p > 7'h1F) && (p < 7'h40))
            r = ((p > 7'h25) && (p < 7'h29)) || (p > 7'h3C) || (p == 7'h30) ||
                (p == 7'h32);
          else if ((p > 7'h0A) && (p < 7'h12) && (p != 7'h0D) && (p != 7'h0F))
            r = 1'b1;
          else if ((p > 7'h0F) && (p < 7'h20))
            r = (p > 7'h17) || (p == 7'h13) || (p == 7'h15);
          else r = 1'b0;
        end
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [7:0]  rs_q, rs_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] lacc_q, lacc_d;
  logic [31:0] brem_q, brem_d;
  logic [7:0]  meta_q, meta_d;
  logic [7:0]  held_q, held_d;
  logic [1:0]  tsc_q, tsc_d;
  logic [7:0]  msb_q [Chans];
  logic [7:0]  msb_d [Chans];
  logic [7:0]  lsb_q [Chans];
  logic [7:0]  lsb_d [Chans];

  logic [3:0]  ch;
  logic [31:0] vacc;
  logic [31:0] base;
  logic        vdone;
  logic        do_first;
  logic [7:0]  st;
  logic [7:0]  cmsb, clsb;
  logic [3:0]  fl;

  always_comb begin
    phase_d = phase_q;
    rs_d    = rs_q;
    tick_d  = tick_q;
    lacc_d  = lacc_q;
    brem_d  = brem_q;
    meta_d  = meta_q;
    held_d  = held_q;
    tsc_d   = tsc_q;
    msb_d   = msb_q;
    lsb_d   = lsb_q;
    push_o  = 1'b0;
    rec_o   = '0;
    do_first = 1'b0;
    st   = rs_q;
    fl   = 4'd1;
    base = 32'd0;
    ch   = rs_q[3:0];

    if (track_begin_i) begin
      tick_d  = 32'd0;
      phase_d = PH_DELTA;
      lacc_d  = 32'd0;
      brem_d  = 32'd0;
      if (tsc_d > 2'd1) tsc_d = 2'd0;
    end
    if (file_begin_i) begin
      for (int i = 0; i < Chans; i++) begin
        msb_d[i] = 8'hFF;
        lsb_d[i] = 8'hFF;
      end
      tsc_d = 2'd1;
    end

    cmsb  = msb_d[ch];
    clsb  = lsb_d[ch];
    vacc  = {lacc_d[24:0], byte_i[6:0]};
    vdone = !byte_i[7];
    rec_o.event_time = tick_d;

    case (phase_d)
      PH_EVENT: begin
        if (!byte_i[7]) begin
          if (rs_q == 8'd0) phase_d = PH_DELTA;
          else do_first = 1'b1;
        end else begin
          lacc_d = 32'd0;
          if (byte_i < 8'hF0) begin
            rs_d = byte_i;
            phase_d = PH_DATA1;
          end else if (byte_i == 8'hF0) phase_d = PH_SYSLEN;
          else if (byte_i == 8'hF7) phase_d = PH_F7LEN;
          else if (byte_i == 8'hFF) phase_d = PH_METATYPE;
          else phase_d = PH_DELTA;
        end
      end
      PH_DATA1: do_first = 1'b1;
      PH_DATA2: begin
        phase_d = PH_DELTA;
        if ((st[7:4] == 4'h9) && (byte_i == 8'd0)) st = {4'h8, ch};
        if ((st[7:4] == 4'hB) && ((held_q == 8'd0) || (held_q == 8'h20))) begin
          if (held_q == 8'h20) lsb_d[ch] = byte_i;
          else msb_d[ch] = byte_i;
        end else begin
          push_o = 1'b1;
          rec_o.kind = KIND_CHAN;
          rec_o.status = st;
          rec_o.first_data = held_q;
          rec_o.second_data = byte_i;
        end
      end
      PH_SYSLEN: begin
        lacc_d = vacc;
        if (vdone) begin
          brem_d  = vacc;
          phase_d = (vacc != 32'd0) ? PH_SYSDATA : PH_DELTA;
          push_o  = 1'b1;
          rec_o.kind = KIND_SYSEX;
          rec_o.first_data = 8'hF0;
          rec_o.sysex_length = vacc + 32'd1;
        end
      end
      PH_SYSDATA: begin
        brem_d = brem_d - 32'd1;
        if (brem_d == 32'd0) phase_d = PH_DELTA;
        push_o = 1'b1;
        rec_o.kind = KIND_SYSEX;
        rec_o.first_data = byte_i;
      end
      PH_F7LEN: begin
        lacc_d = vacc;
        if (vdone) begin
          brem_d  = vacc;
          phase_d = (vacc != 32'd0) ? PH_SKIP : PH_DELTA;
        end
      end
      PH_SKIP: begin
        if (brem_d != 32'd0) brem_d = brem_d - 32'd1;
        if (brem_d == 32'd0) phase_d = PH_DELTA;
      end
      PH_METATYPE: begin
        meta_d  = byte_i;
        lacc_d  = 32'd0;
        phase_d = PH_METALEN;
      end
      PH_METALEN: begin
        if (!vdone) begin
          lacc_d = vacc;
        end else begin
          brem_d = vacc;
          lacc_d = 32'd0;
          if (meta_q == 8'h51) begin
            if (vacc == 32'd0) begin
              phase_d = PH_DELTA;
              push_o = 1'b1;
              rec_o.kind = KIND_TEMPO;
            end else phase_d = PH_TEMPO;
          end else if ((meta_q == 8'h58) && (tsc_d != 2'd0)) begin
            phase_d = PH_TSBEATS;
          end else begin
            phase_d = (vacc != 32'd0) ? PH_SKIP : PH_DELTA;
          end
        end
      end
      PH_TEMPO: begin
        lacc_d = {lacc_d[23:0], byte_i};
        brem_d = brem_d - 32'd1;
        if (brem_d == 32'd0) begin
          phase_d = PH_DELTA;
          push_o = 1'b1;
          rec_o.kind = KIND_TEMPO;
          rec_o.tempo_micros = lacc_d;
        end
      end
      PH_TSBEATS: begin
        held_d  = byte_i;
        tsc_d   = 2'd2;
        phase_d = PH_TSEXP;
      end
      PH_TSEXP: begin
        brem_d  = (brem_d > 32'd2) ? brem_d - 32'd2 : 32'd0;
        phase_d = (brem_d != 32'd0) ? PH_SKIP : PH_DELTA;
        push_o = 1'b1;
        rec_o.kind = KIND_TSIG;
        rec_o.first_data = held_q;
        rec_o.second_data = (byte_i[7:3] == 5'd0) ? (8'd1 << byte_i[2:0]) : 8'd0;
      end
      default: begin
        base = (phase_d == PH_DELTA) ? lacc_d : 32'd0;
        vacc = {base[24:0], byte_i[6:0]};
        phase_d = PH_DELTA;
        if (vdone) begin
          tick_d  = tick_d + vacc;
          lacc_d  = 32'd0;
          phase_d = PH_EVENT;
        end else lacc_d = vacc;
      end
    endcase

    if (do_first) begin
      if (rs_q[7:4] == 4'hC) begin
        phase_d = PH_DELTA;
        if ((cmsb != 8'hFF) || (clsb != 8'hFF)) begin
          fl[1] = 1'b1;
          if (gs_sound(cmsb[6:0], clsb[6:0], byte_i[6:0])) begin
            fl[3] = 1'b1;
            if ((cmsb[6:0] == 7'd0) && (clsb[6:0] == 7'd0)) fl[2] = 1'b1;
          end
        end else fl[2] = 1'b1;
        push_o = prog_cap_i;
        rec_o.kind = KIND_PROG;
        rec_o.status = rs_q;
        rec_o.first_data = byte_i;
        rec_o.instrument_flags = fl;
        rec_o.bank_high = cmsb;
        rec_o.bank_low = clsb;
      end else if (rs_q[7:4] == 4'hD) begin
        phase_d = PH_DELTA;
        push_o = 1'b1;
        rec_o.kind = KIND_CHAN;
        rec_o.status = rs_q;
        rec_o.first_data = byte_i;
      end else begin
        held_d  = byte_i;
        phase_d = PH_DATA2;
      end
    end

    if (!acc_i) push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      rs_q    <= 8'd0;
      tick_q  <= 32'd0;
      lacc_q  <= 32'd0;
      brem_q  <= 32'd0;
      meta_q  <= 8'd0;
      held_q  <= 8'd0;
      tsc_q   <= 2'd1;
      for (int i = 0; i < Chans; i++) begin
        msb_q[i] <= 8'hFF;
        lsb_q[i] <= 8'hFF;
      end
    end else if (acc_i) begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      tick_q  <= tick_d;
      lacc_q  <= lacc_d;
      brem_q  <= brem_d;
      meta_q  <= meta_d;
      held_q  <= held_d;
      tsc_q   <= tsc_d;
      msb_q   <= msb_d;
      lsb_q   <= lsb_d;
    end
  end

endmodule

FILE: rtl/mtep_fifo.sv
// ----------------------------------------------------------------------------
// mtep_fifo
// short result queue between parser and rescaler
// ----------------------------------------------------------------------------
module mtep_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtep_pkg::rec_t wdata_i,
  input  logic           pop_i,
  output mtep_pkg::rec_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import mtep_pkg::*;
  `include "midi_track_event_parser_assert.svh"

  rec_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'(QDepth));
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `MTEP_ASSERT(a_no_overflow, !(push_i && full_o && !pop_i), "push into full queue")
  `MTEP_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from empty queue")
  `MTEP_ASSERT(a_count_range, count_q <= 2'(QDepth), "queue count out of range")
  `MTEP_ASSERT_NEXT(a_push_seen, push_i && !pop_i, !empty_o, "push lost")

endmodule

FILE: rtl/mtep_back.sv
// ----------------------------------------------------------------------------
// mtep_back
// tick rescaler with bit-serial divider and output register
// ----------------------------------------------------------------------------
module mtep_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mtep_pkg::TpqW-1:0]  tpq_i,
  input  logic                       empty_i,
  input  mtep_pkg::rec_t             rdata_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output mtep_pkg::rec_t             out_o
);
  import mtep_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_ADD, ST_DIV, ST_HOLD} state_e;

  state_e          state_q;
  rec_t            rec_q;
  rec_t            out_q;
  rec_t            hold_rec;
  logic            vld_q;
  logic [NumW-1:0] num_q;
  logic [15:0]     rem_q;
  logic [5:0]      cnt_q;
  logic [15:0]     dvs;
  logic [15:0]     trial;
  logic            qbit;
  logic            out_free;
  logic            scaled;
  logic            load_out;

  assign dvs      = (tpq_i == '0) ? 16'd1 : {1'b0, tpq_i};
  assign trial    = {rem_q[14:0], num_q[NumW-1]};
  assign qbit     = (trial >= dvs);
  assign out_free = !vld_q || out_ready_i;
  assign scaled   = (rdata_i.kind == KIND_PROG) || (rdata_i.kind == KIND_TEMPO) ||
                    (rdata_i.kind == KIND_TSIG);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i && (scaled || out_free);
  assign load_out = ((state_q == ST_IDLE) && pop_o && !scaled) ||
                    ((state_q == ST_HOLD) && out_free);

  always_comb begin
    hold_rec = rec_q;
    hold_rec.event_time = (num_q[NumW-1:32] != '0) ? 32'hFFFF_FFFF : num_q[31:0];
  end

  assign out_valid_o = vld_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      cnt_q   <= 6'd0;
      rec_q   <= '0;
      out_q   <= '0;
      num_q   <= '0;
      rem_q   <= 16'd0;
    end else begin
      if (load_out) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            rec_q <= rdata_i;
            if (scaled) state_q <= ST_MUL;
            else out_q <= rdata_i;
          end
        end
        ST_MUL: begin
          num_q   <= NumW'(rec_q.event_time) * NumW'(OutTicksPerQuarter);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          num_q   <= num_q + NumW'(dvs >> 1);
          rem_q   <= 16'd0;
          cnt_q   <= 6'(NumW);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= qbit ? trial - dvs : trial;
          num_q <= {num_q[NumW-2:0], qbit};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            out_q   <= hold_rec;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/mtep_tb_pkg.sv
// ----------------------------------------------------------------------------
// mtep_tb_pkg
// byte codes shared by the midi parser stimulus and checker
// ----------------------------------------------------------------------------
package mtep_tb_pkg;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TSIG   = 8'h58;
  localparam logic [7:0] CC_BANK_MSB = 8'h00;
  localparam logic [7:0] CC_BANK_LSB = 8'h20;
  localparam logic [3:0] CLS_NOTE_OFF = 4'h8;
  localparam logic [3:0] CLS_NOTE_ON  = 4'h9;
  localparam logic [3:0] CLS_CTRL     = 4'hB;
  localparam logic [3:0] CLS_PROGRAM  = 4'hC;
  localparam logic [3:0] CLS_PRESSURE = 4'hD;

endpackage

FILE: dv/mtep_checker.sv
// ----------------------------------------------------------------------------
// mtep_checker
// predicts midi parser events from accepted track bytes and compares them
// ----------------------------------------------------------------------------
// byte and register transfers update a private parser model; each output
// transfer is compared field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mtep_checker
  import mtep_pkg::*;
  import mtep_tb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_ready_i,
  input  logic [7:0]    s_data_i,
  input  logic [1:0]    s_user_i,
  input  logic          m_valid_i,
  input  logic          m_ready_i,
  input  logic [143:0]  m_data_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [14:0]   cfg_data_i,
  output int unsigned   fail_cnt_o,
  output int unsigned   pending_o
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_EVENT, PH_DATA1, PH_DATA2, PH_SYSLEN, PH_SYSDATA, PH_F7LEN,
    PH_SKIP, PH_MTYPE, PH_MLEN, PH_TEMPO, PH_TSBEATS, PH_TSEXP
  } phase_e;

  rec_t        event_q[$];
  logic [14:0] tpq;
  logic        pcap;
  logic [7:0]  run_st, meta, held;
  logic [31:0] ticks, vacc, remain;
  phase_e      ph;
  logic [7:0]  bank_msb[Chans];
  logic [7:0]  bank_lsb[Chans];
  logic [1:0]  tsig_cap;

  assign pending_o = event_q.size();

  function automatic logic [31:0] scale_ticks(logic [31:0] t);
    longint unsigned d, q;
    d = (tpq == 0) ? 1 : tpq;
    q = (longint'(t) * OutTicksPerQuarter + d / 2) / d;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic gs_voice(logic [6:0] msb, logic [6:0] lsb, logic [6:0] p);
    if (lsb != 0) return 1'b0;
    case (msb)
      0: return 1'b1;
      6, 7: return p == 7'h7D;
      24: return p == 7'h04 || p == 7'h06;
      9: return p == 7'h0E || p == 7'h76 || p == 7'h7D;
      2: return p == 7'h66 || p == 7'h78 || p > 7'h79;
      3: return p > 7'h79;
      4, 5: return p == 7'h7A || (p > 7'h7B && p < 7'h7F);
      32: return p == 7'h10 || p == 7'h11 || p == 7'h18 || p == 7'h34;
      1: return p == 7'h26 || p == 7'h39 || p == 7'h3C || p == 7'h50 || p == 7'h51 ||
                p == 7'h62 || p == 7'h66 || p == 7'h68 || p > 7'h77;
      16: return p == 7'h00 || p == 7'h04 || p == 7'h05 || p == 7'h06 || p == 7'h10 ||
                 p == 7'h13 || p == 7'h18 || p == 7'h19 || p == 7'h1C || p == 7'h27 ||
                 p == 7'h3E || p == 7'h3F;
      8: begin
        if (p < 7'h07 || p == 7'h7D) return 1'b1;
        if (p > 7'h3F && p < 7'h50) return 1'b0;
        if (p > 7'h4F && p < 7'h72) return p == 7'h50 || p == 7'h51 || p == 7'h6B;
        if (p > 7'h1F && p < 7'h40)
          return (p > 7'h25 && p < 7'h29) || p > 7'h3C || p == 7'h30 || p == 7'h32;
        if (p > 7'h0A && p < 7'h12 && p != 7'h0D && p != 7'h0F) return 1'b1;
        if (p > 7'h0F && p < 7'h20) return p > 7'h17 || p == 7'h13 || p == 7'h15;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_event(logic [2:0] k, logic [31:0] t, logic [7:0] st, logic [7:0] d1,
                           logic [7:0] d2, logic [3:0] fl, logic [7:0] bh,
                           logic [7:0] bl, logic [31:0] tempo, logic [31:0] slen);
    rec_t r;
    r.kind = k; r.event_time = t; r.status = st; r.first_data = d1;
    r.second_data = d2; r.instrument_flags = fl; r.bank_high = bh; r.bank_low = bl;
    r.tempo_micros = tempo; r.sysex_length = slen;
    event_q.push_back(r);
  endtask

  // returns 1 when the variable-length number is complete
  function automatic logic vlq_add(logic [7:0] b);
    vacc = (vacc << 7) + b[6:0];
    return !b[7];
  endfunction

  task automatic first_byte(logic [7:0] b);
    logic [3:0] ch;
    logic [3:0] fl;
    ch = run_st[3:0];
    if (run_st[7:4] == CLS_PROGRAM) begin
      ph = PH_DELTA;
      if (pcap) begin
        fl = 4'b0001;
        if (bank_msb[ch] != 8'hFF || bank_lsb[ch] != 8'hFF) begin
          fl[1] = 1'b1;
          if (gs_voice(bank_msb[ch][6:0], bank_lsb[ch][6:0], b[6:0])) begin
            fl[3] = 1'b1;
            if (bank_msb[ch][6:0] == 0 && bank_lsb[ch][6:0] == 0) fl[2] = 1'b1;
          end
        end else begin
          fl[2] = 1'b1;
        end
        add_event(KIND_PROG, scale_ticks(ticks), run_st, b, 0, fl, bank_msb[ch],
                  bank_lsb[ch], 0, 0);
      end
    end else if (run_st[7:4] == CLS_PRESSURE) begin
      ph = PH_DELTA;
      add_event(KIND_CHAN, ticks, run_st, b, 0, 0, 0, 0, 0, 0);
    end else begin
      held = b;
      ph = PH_DATA2;
    end
  endtask

  task automatic parse_byte(logic [7:0] b, logic [1:0] u);
    logic [7:0] st;
    if (u[0]) begin
      ticks = 0; ph = PH_DELTA; vacc = 0; remain = 0;
      if (tsig_cap > 1) tsig_cap = 0;
    end
    if (u[1]) begin
      foreach (bank_msb[i]) begin
        bank_msb[i] = 8'hFF;
        bank_lsb[i] = 8'hFF;
      end
      tsig_cap = 1;
    end
    case (ph)
      PH_EVENT: begin
        if (!b[7]) begin
          if (run_st == 0) ph = PH_DELTA;
          else first_byte(b);
        end else begin
          vacc = 0;
          if (b < ST_SYSEX) begin
            run_st = b;
            ph = PH_DATA1;
          end else if (b == ST_SYSEX) ph = PH_SYSLEN;
          else if (b == ST_ESCAPE) ph = PH_F7LEN;
          else if (b == ST_META) ph = PH_MTYPE;
          else ph = PH_DELTA;
        end
      end
      PH_DATA1: first_byte(b);
      PH_DATA2: begin
        st = run_st;
        ph = PH_DELTA;
        if (st[7:4] == CLS_NOTE_ON && b == 0) st[7:4] = CLS_NOTE_OFF;
        if (st[7:4] == CLS_CTRL && (held == CC_BANK_MSB || held == CC_BANK_LSB)) begin
          if (held == CC_BANK_LSB) bank_lsb[st[3:0]] = b;
          else bank_msb[st[3:0]] = b;
        end else begin
          add_event(KIND_CHAN, ticks, st, held, b, 0, 0, 0, 0, 0);
        end
      end
      PH_SYSLEN: if (vlq_add(b)) begin
        remain = vacc;
        ph = (vacc != 0) ? PH_SYSDATA : PH_DELTA;
        add_event(KIND_SYSEX, ticks, 0, ST_SYSEX, 0, 0, 0, 0, 0, vacc + 1);
      end
      PH_SYSDATA: begin
        remain = remain - 1;
        if (remain == 0) ph = PH_DELTA;
        add_event(KIND_SYSEX, ticks, 0, b, 0, 0, 0, 0, 0, 0);
      end
      PH_F7LEN: if (vlq_add(b)) begin
        remain = vacc;
        ph = (remain != 0) ? PH_SKIP : PH_DELTA;
      end
      PH_SKIP: begin
        if (remain != 0) remain = remain - 1;
        if (remain == 0) ph = PH_DELTA;
      end
      PH_MTYPE: begin
        meta = b;
        vacc = 0;
        ph = PH_MLEN;
      end
      PH_MLEN: if (vlq_add(b)) begin
        remain = vacc;
        vacc = 0;
        if (meta == META_TEMPO) begin
          if (remain == 0) begin
            ph = PH_DELTA;
            add_event(KIND_TEMPO, scale_ticks(ticks), 0, 0, 0, 0, 0, 0, 0, 0);
          end else begin
            ph = PH_TEMPO;
          end
        end else if (meta == META_TSIG && tsig_cap != 0) begin
          ph = PH_TSBEATS;
        end else begin
          ph = (remain != 0) ? PH_SKIP : PH_DELTA;
        end
      end
      PH_TEMPO: begin
        vacc = (vacc << 8) + b;
        remain = remain - 1;
        if (remain == 0) begin
          ph = PH_DELTA;
          add_event(KIND_TEMPO, scale_ticks(ticks), 0, 0, 0, 0, 0, 0, vacc, 0);
        end
      end
      PH_TSBEATS: begin
        held = b;
        tsig_cap = 2;
        ph = PH_TSEXP;
      end
      PH_TSEXP: begin
        remain = (remain > 2) ? remain - 2 : 0;
        ph = (remain != 0) ? PH_SKIP : PH_DELTA;
        add_event(KIND_TSIG, scale_ticks(ticks), 0, held,
                  (b < 8) ? (8'd1 << b) : 8'd0, 0, 0, 0, 0, 0);
      end
      default: begin
        if (ph != PH_DELTA) vacc = 0;
        ph = PH_DELTA;
        if (vlq_add(b)) begin
          ticks = ticks + vacc;
          vacc = 0;
          ph = PH_EVENT;
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  task automatic check_output(logic [143:0] m);
    rec_t e;
    if (event_q.size() == 0) begin
      $display("%0t: unexpected event, actual %0h", $time, m);
      fail_cnt_o++;
    end else begin
      e = event_q.pop_front();
      check_field("kind", e.kind, m[2:0]);
      check_field("event_time", e.event_time, m[34:3]);
      check_field("status", e.status, m[42:35]);
      check_field("first_data", e.first_data, m[50:43]);
      check_field("second_data", e.second_data, m[58:51]);
      check_field("instrument_flags", e.instrument_flags, m[62:59]);
      check_field("bank_high", e.bank_high, m[70:63]);
      check_field("bank_low", e.bank_low, m[78:71]);
      check_field("tempo_micros", e.tempo_micros, m[110:79]);
      check_field("sysex_length", e.sysex_length, m[142:111]);
    end
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq = OutTicksPerQuarter; pcap = 0;
      run_st = 0; ticks = 0; ph = PH_DELTA; vacc = 0; remain = 0;
      meta = 0; held = 0; tsig_cap = 1;
      foreach (bank_msb[i]) begin
        bank_msb[i] = 8'hFF;
        bank_lsb[i] = 8'hFF;
      end
      event_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TPQ) tpq = cfg_data_i;
        else pcap = cfg_data_i[0];
      end
      if (m_valid_i && m_ready_i) check_output(m_data_i);
      if (s_valid_i && s_ready_i) parse_byte(s_data_i, s_user_i);
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the midi track event parser
// ----------------------------------------------------------------------------
// drives directed and random track byte streams under several register
// settings with random gaps on both channels and one long output stall;
// mtep_checker predicts and compares every event.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mtep_pkg::*;
  import mtep_tb_pkg::*;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 80;
  localparam int unsigned PhaseBytes = 65;

  typedef struct {
    logic [7:0] b;
    logic [1:0] u;
  } track_byte_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid, s_axis_tready;
  logic [7:0]    s_axis_tdata;
  logic [1:0]    s_axis_tuser;
  logic          m_axis_tvalid, m_axis_tready;
  logic [143:0]  m_axis_tdata;
  logic          cfg_we_i, cfg_idx_i;
  logic [14:0]   cfg_data_i;
  int unsigned   fail_cnt, pending;

  track_byte_t   byte_q[$];
  logic [1:0]    start_flags;
  logic          long_hold;
  int unsigned   idle_cycles;

  always #5 clk_i = ~clk_i;

  midi_track_event_parser DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  mtep_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_user_i(s_axis_tuser), .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic put(logic [7:0] b);
    byte_q.push_back('{b, start_flags});
    start_flags = 2'b00;
  endtask

  task automatic put_vlq(logic [31:0] v);
    logic [7:0] grp[$];
    do begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    grp[grp.size() - 1][7] = 1'b0;
    foreach (grp[i]) put(grp[i]);
  endtask

  task automatic put_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) put_vlq(0);
    else if (r < 85) put_vlq($urandom_range(1, 127));
    else if (r < 97) put_vlq($urandom_range(128, 16383));
    else put_vlq($urandom_range(16384, 32'h0FFF_FFFF));
  endtask

  task automatic put_bank(logic [3:0] ch);
    logic [7:0] banks[15] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 16, 24, 32, 127, 0};
    banks[14] = $urandom_range(0, 255);
    put_delta(); put({CLS_CTRL, ch}); put(CC_BANK_MSB); put(banks[$urandom_range(0, 14)]);
    put_delta(); put({CLS_CTRL, ch}); put(CC_BANK_LSB);
    put(($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
  endtask

  task automatic put_event();
    int unsigned r, n;
    logic [3:0] ch;
    logic [3:0] cls;
    r = $urandom_range(0, 99);
    ch = $urandom_range(0, 15);
    if (r < 4) begin
      put($urandom_range(0, 255));
      return;
    end
    put_delta();
    if (r < 40) begin
      cls = $urandom_range(8, 14);
      put({cls, ch});
      put(($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 127)));
      if (cls != CLS_PROGRAM && cls != CLS_PRESSURE)
        put((cls == CLS_NOTE_ON && $urandom_range(0, 3) == 0) ? 8'd0
                                                               : 8'($urandom_range(0, 255)));
    end else if (r < 50) begin
      put($urandom_range(0, 127));
      put($urandom_range(0, 127));
    end else if (r < 58) begin
      put_bank(ch);
    end else if (r < 68) begin
      if ($urandom_range(0, 1)) put_bank(ch);
      put_delta();
      put({CLS_PROGRAM, ch});
      put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(120, 127)));
    end else if (r < 74) begin
      n = $urandom_range(0, 5);
      put(ST_SYSEX); put_vlq(n);
      repeat (n) put($urandom_range(0, 255));
    end else if (r < 78) begin
      n = $urandom_range(0, 4);
      put(ST_ESCAPE); put_vlq(n);
      repeat (n) put($urandom_range(0, 255));
    end else if (r < 85) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 3;
      put(ST_META); put(META_TEMPO); put_vlq(n);
      repeat (n) put($urandom_range(0, 255));
    end else if (r < 91) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
      put(ST_META); put(META_TSIG); put_vlq(n);
      put($urandom_range(0, 255)); put($urandom_range(0, 10));
      repeat ((n > 2) ? n - 2 : 0) put($urandom_range(0, 255));
    end else if (r < 97) begin
      n = $urandom_range(0, 4);
      put(ST_META); put($urandom_range(0, 127)); put_vlq(n);
      repeat (n) put($urandom_range(0, 255));
    end else begin
      put(($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF1, 8'hF6))
                                      : 8'($urandom_range(8'hF8, 8'hFE)));
    end
  endtask

  task automatic put_directed();
    start_flags = 2'b11;
    put(8'h40); put(8'h10);
    put(0); put(8'h93); put(8'h3C); put(8'h00);
    put(0); put(8'h3C); put(8'h7F);
    put(0); put({CLS_CTRL, 4'h3}); put(CC_BANK_MSB); put(8'h00);
    put(0); put({CLS_PROGRAM, 4'h3}); put(8'h10);
    put(0); put(ST_SYSEX); put(8'h00);
    put(0); put(ST_ESCAPE); put(8'h01); put(8'h55);
    put(0); put(8'hF3);
    put(0); put(ST_META); put(META_TEMPO); put(8'h00);
    put(0); put(ST_META); put(META_TSIG); put(8'h01); put(8'h04); put(8'h09);
    put(8'h8F); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
    put(ST_META); put(META_TEMPO); put(8'h03); put(8'h07); put(8'hA1); put(8'h20);
  endtask

  task automatic send_bytes();
    int unsigned gap;
    while (byte_q.size() != 0) begin
      gap = pick_gap();
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = byte_q[0].b;
      s_axis_tuser  = byte_q[0].u;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      void'(byte_q.pop_front());
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [14:0] tpq, logic pcap);
    cfg_we_i = 1'b1; cfg_idx_i = CFG_TPQ; cfg_data_i = tpq;
    @(negedge clk_i);
    cfg_idx_i = CFG_PCAP; cfg_data_i = {14'd0, pcap};
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // output side: random stalls plus one long hold when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk_i);
        if ($urandom_range(0, 3) != 0) begin
          m_axis_tready = 1'b0;
          repeat (pick_gap()) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [14:0] tpq_set[5] = '{15'd1, 15'd32767, 15'd0, 15'd96, 15'd480};
    logic        pcap_set[5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = 0; s_axis_tuser = 0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_TPQ; cfg_data_i = 0;
    start_flags = 2'b00; long_hold = 1'b0; idle_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    put_directed();
    send_bytes();
    drain();
    for (int p = 0; p < 5; p++) begin
      if (p == 4) write_regs($urandom_range(1, 32767), $urandom_range(0, 1));
      else write_regs(tpq_set[p], pcap_set[p]);
      if (p == 1) long_hold = 1'b1;
      while (byte_q.size() < PhaseBytes) begin
        start_flags = {($urandom_range(0, 2) == 0), 1'b1};
        repeat ($urandom_range(3, 10)) put_event();
      end
      send_bytes();
      drain();
    end
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: midi_track_event_parser.f
+incdir+rtl
rtl/mtep_pkg.sv
rtl/mtep_front.sv
rtl/mtep_fifo.sv
rtl/mtep_back.sv
rtl/midi_track_event_parser.sv
dv/mtep_tb_pkg.sv
dv/mtep_checker.sv
dv/tb_top.sv
